// ----- hw/rtl/tta_pkg.sv -----
`timescale 1ns / 1ps

package tta_pkg;

  // Size limits of the texture and derived widths
  localparam int unsigned MAX_SIZE_LOG2 = 10;
  localparam int unsigned COORD_W       = 10;
  localparam int unsigned LOG_W         = 4;
  localparam int unsigned TW_W          = 2 * MAX_SIZE_LOG2;
  localparam int unsigned POS_W         = $clog2(TW_W + 1);
  localparam int unsigned IDX_W         = $clog2(MAX_SIZE_LOG2);
  localparam int unsigned BLK_W         = 3;
  localparam int unsigned OFFSET_W      = 21;
  localparam int unsigned SUB_W         = 4;
  localparam int unsigned MIN_SIZE_LOG2 = 3;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_LOG2   = 2'd0,
    REG_HEIGHT_LOG2  = 2'd1,
    REG_TEXEL_FORMAT = 2'd2,
    REG_VQ_ENABLE    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    FMT_16BPP_2X2 = 2'd0,
    FMT_PAL8_2X4  = 2'd1,
    FMT_PAL4_4X4  = 2'd2
  } texel_fmt_e;

  // Block size as log2 of texels per block
  localparam logic [BLK_W-1:0] BLK_LOG2_2X2 = 3'd2;
  localparam logic [BLK_W-1:0] BLK_LOG2_2X4 = 3'd3;
  localparam logic [BLK_W-1:0] BLK_LOG2_4X4 = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] tex_x;
    logic [COORD_W-1:0] tex_y;
  } req_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [SUB_W-1:0]    sub_index;
    logic                out_of_range;
  } rsp_t;

  // Decoded configuration handed to the address datapath
  typedef struct packed {
    logic [LOG_W-1:0] wl;
    logic [LOG_W-1:0] hl;
    logic [BLK_W-1:0] blk_log2;
    logic             vq;
  } cfg_t;

endpackage

// ----- hw/rtl/tta_cfg_regs.sv -----
`timescale 1ns / 1ps

module tta_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tta_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output tta_pkg::cfg_t                 cfg_o
);
  import tta_pkg::*;

  logic [LOG_W-1:0] width_log2_q;
  logic [LOG_W-1:0] height_log2_q;
  logic [1:0]       texel_format_q;
  logic             vq_enable_q;
  logic             wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q   <= LOG_W'(MIN_SIZE_LOG2);
      height_log2_q  <= LOG_W'(MIN_SIZE_LOG2);
      texel_format_q <= FMT_16BPP_2X2;
      vq_enable_q    <= 1'b0;
    end else if (wr_en) begin
      case (cfg_index_i)
        REG_WIDTH_LOG2:   width_log2_q   <= cfg_data_i[LOG_W-1:0];
        REG_HEIGHT_LOG2:  height_log2_q  <= cfg_data_i[LOG_W-1:0];
        REG_TEXEL_FORMAT: texel_format_q <= cfg_data_i[1:0];
        REG_VQ_ENABLE:    vq_enable_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp a size to the supported range
  function automatic logic [LOG_W-1:0] clamp_log2(input logic [LOG_W-1:0] v);
    logic [LOG_W-1:0] r;
    if (v < LOG_W'(MIN_SIZE_LOG2)) r = LOG_W'(MIN_SIZE_LOG2);
    else if (v > LOG_W'(MAX_SIZE_LOG2)) r = LOG_W'(MAX_SIZE_LOG2);
    else r = v;
    return r;
  endfunction

  // Decode sizes and block shape; the reserved format acts as 4x4
  always_comb begin
    cfg_o.wl = clamp_log2(width_log2_q);
    cfg_o.hl = clamp_log2(height_log2_q);
    cfg_o.vq = vq_enable_q;
    case (texel_format_q)
      FMT_16BPP_2X2: cfg_o.blk_log2 = BLK_LOG2_2X2;
      FMT_PAL8_2X4:  cfg_o.blk_log2 = BLK_LOG2_2X4;
      default:       cfg_o.blk_log2 = BLK_LOG2_4X4;
    endcase
  end

endmodule

// ----- hw/rtl/tta_addr_calc.sv -----
`timescale 1ns / 1ps

module tta_addr_calc (
  input  tta_pkg::req_t req_i,
  input  tta_pkg::cfg_t cfg_i,
  output tta_pkg::rsp_t rsp_o
);
  import tta_pkg::*;

  logic [COORD_W-1:0]    x_m;
  logic [COORD_W-1:0]    y_m;
  logic [COORD_W-1:0]    tail_src;
  logic [LOG_W-1:0]      min_l;
  logic [POS_W-1:0]      shared_bits;
  logic [POS_W-1:0]      k;
  logic [TW_W-1:0]       tw;
  logic [TW_W-1:0]       blk;
  logic [TW_W+2:0]       offset_full;
  logic [SUB_W-1:0]      sub_mask;

  // Flag and mask coordinates beyond the configured size
  assign rsp_o.out_of_range = (|(req_i.tex_x >> cfg_i.wl)) | (|(req_i.tex_y >> cfg_i.hl));
  assign x_m = req_i.tex_x & ~({COORD_W{1'b1}} << cfg_i.wl);
  assign y_m = req_i.tex_y & ~({COORD_W{1'b1}} << cfg_i.hl);

  // Shared levels interleave y below x; leftover bits of the larger side follow
  assign min_l       = (cfg_i.wl < cfg_i.hl) ? cfg_i.wl : cfg_i.hl;
  assign shared_bits = {min_l, 1'b0};
  assign tail_src    = (cfg_i.wl > cfg_i.hl) ? x_m : y_m;

  always_comb begin
    k = '0;
    for (int p = 0; p < TW_W; p++) begin
      if (POS_W'(p) < shared_bits) begin
        tw[p] = p[0] ? x_m[p/2] : y_m[p/2];
      end else begin
        k = POS_W'(p) - POS_W'(min_l);
        tw[p] = (k < POS_W'(MAX_SIZE_LOG2)) ? tail_src[k[IDX_W-1:0]] : 1'b0;
      end
    end
  end

  // Split the index into block number and slot
  assign blk         = tw >> cfg_i.blk_log2;
  assign offset_full = cfg_i.vq ? {3'b000, blk} : {blk, 3'b000};
  assign sub_mask    = ~({SUB_W{1'b1}} << cfg_i.blk_log2);

  assign rsp_o.byte_offset = offset_full[OFFSET_W-1:0];
  assign rsp_o.sub_index   = tw[SUB_W-1:0] & sub_mask;

endmodule

// ----- hw/rtl/twiddled_texture_address.sv -----
`timescale 1ns / 1ps
// Path: an accepted request is held in the input register, then its result
// and strobe are held in the result register.
// Throughput: one request per cycle; busy never rises, and the receiver
// cannot stall the result strobe.
// Reset: configuration returns to 8x8 texels, 2x2 blocks, direct mode;
// in-flight requests are dropped.
module twiddled_texture_address (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  tta_pkg::req_t                  req_i,
  output logic                           rsp_valid_o,
  output tta_pkg::rsp_t                  rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tta_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tta_pkg::*;

  cfg_t cfg;
  req_t req_q;
  logic req_valid_q;
  rsp_t rsp_d;
  rsp_t rsp_q;
  logic rsp_valid_q;

  assign busy = 1'b0;

  tta_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start & ~busy) begin
      req_q <= req_i;
    end
  end

  tta_addr_calc u_calc (
    .req_i (req_q),
    .cfg_i (cfg),
    .rsp_o (rsp_d)
  );

  // Register the result and its strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- hw/rtl/tta_checker.sv -----
`timescale 1ns / 1ps

module tta_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           rsp_valid_o,
  input tta_pkg::rsp_t                  rsp_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o
);
  import tta_pkg::*;

  // Every accepted request gives a result strobe
  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 rsp_valid_o)
    else $error("accepted request produced no result");

  // No strobe without an earlier accepted request
  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(start && !busy, 2))
    else $error("result strobe without a request");

  // The block never holds off requests or configuration writes
  a_never_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> (!busy && cfg_ready_o))
    else $error("request or configuration stalled");

  // A result slot shown while a configuration write is offered never exceeds the largest block
  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && cfg_valid_i) |-> (rsp_o.sub_index <= SUB_W'(15)))
    else $error("slot index out of range");

endmodule

bind twiddled_texture_address tta_checker u_tta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
